[rtl/mrp_pkg.sv]
// shared types and constants for the mips elf relocation patcher
package mrp_pkg;

   // relocation type codes
   localparam logic [7:0] REL_WORD32  = 8'd2;
   localparam logic [7:0] REL_JUMP26  = 8'd4;
   localparam logic [7:0] REL_HI16    = 8'd5;
   localparam logic [7:0] REL_LO16    = 8'd6;
   localparam logic [7:0] REL_GPREL16 = 8'd7;

   // section indexes below this are local
   localparam logic [15:0] LOCAL_LIMIT = 16'hff00;

   // rounding term for the hi16 carry
   localparam logic [31:0] HI_ROUND = 32'h0000_8000;

   // configuration register indexes
   typedef logic [2:0] csr_index_type;
   localparam csr_index_type CSR_SEGMENT_BASE  = 3'd0;
   localparam csr_index_type CSR_SHORTS_OFFSET = 3'd1;
   localparam csr_index_type CSR_HOLE_START    = 3'd2;
   localparam csr_index_type CSR_HOLE_END      = 3'd3;
   localparam csr_index_type CSR_TARGET_BASE   = 3'd4;

   typedef enum logic [2:0] {
      STATUS_OK       = 3'd0,
      STATUS_LO_NO_HI = 3'd1,
      STATUS_BAD_TYPE = 3'd2,
      STATUS_OVERFLOW = 3'd3,
      STATUS_HALTED   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADDR,
      S_CALC,
      S_RELOC,
      S_CARRY,
      S_FLUSH,
      S_FINAL
   } state_type;

   typedef struct packed {
      logic        first_of_table;
      logic [7:0]  reloc_kind;
      logic [15:0] sym_section;
      logic [31:0] sym_value;
      logic [31:0] target_offset;
      logic [31:0] target_word;
   } req_item_type;

   typedef struct packed {
      logic        write_enable;
      logic [31:0] write_address;
      logic [31:0] write_data;
      status_type  status;
      logic        last;
   } rsp_item_type;

   typedef struct packed {
      csr_index_type index;
      logic [31:0]   data;
   } csr_item_type;

   // one held hi16 target
   typedef struct packed {
      logic [31:0] address;
      logic [15:0] upper;
   } pend_entry_type;

endpackage

[rtl/mrp_chan_if.sv]
// valid/ready channel carrying one item of a given payload type
interface mrp_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

[rtl/mrp_pending_buf.sv]
// pending hi16 buffer: one write port, one registered read port
module mrp_pending_buf #(
   parameter int DEPTH = 16,
   // index width follows the depth
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [IDX_W-1:0]       wr_idx,
   input  mrp_pkg::pend_entry_type wr_entry,
   input  logic [IDX_W-1:0]       rd_idx,
   output mrp_pkg::pend_entry_type rd_entry
);
   import mrp_pkg::*;

   pend_entry_type mem_ff [DEPTH];
   pend_entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_idx] <= wr_entry;
      end
      rd_entry_ff <= mem_ff[rd_idx];
   end

   assign rd_entry = rd_entry_ff;

endmodule

[rtl/mips_elf_relocation_patcher_top.sv]
// top level of the mips elf32 rel relocation patcher
//
// req_chan takes one rel entry per item together with the current target word.
// rsp_chan gives one or more result items per entry; last marks the final one.
// csr_chan writes the five configuration registers; it is always ready. The user
// must write it only while the block is idle; the block does not enforce this.
// req_chan is ready only in the idle state: one entry is worked at a time by
// a small sequencer around a single shared 32-bit adder.
// steps per entry, from acceptance to the final result loaded:
//   no-write, error or hi16 entry: address add, then result
//   word32, jump26, gprel16: address add, patch add, result
//   lo16 with nothing pending: address add, two adds for the relocation, result
//   lo16 that flushes held hi16s: as above plus a rounding add, then one held
//   entry a cycle while the receiver takes them, via the registered buffer read port
// after the final result the sequencer returns to idle before the next entry is taken.
// results sit in an output register; while the receiver stalls the sequencer
// holds in a step that gives a result and no result is lost or repeated.
// reset (synchronous) clears the configuration registers, the pending and
// halt state and the output valid flag; buffer contents need no clearing since
// only entries below the fill count are ever read.
module mips_elf_relocation_patcher_top #(
   parameter int PENDING_DEPTH = 16
) (
   input logic        clock,
   input logic        reset,
   mrp_chan_if.sink   req_chan,
   mrp_chan_if.source rsp_chan,
   mrp_chan_if.sink   csr_chan
);
   import mrp_pkg::*;

   localparam int CNT_W = $clog2(PENDING_DEPTH + 1);
   localparam int IDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(PENDING_DEPTH);

   // sequencer state
   state_type state_ff, state_in;

   // configuration registers
   logic [31:0] segment_base_ff, shorts_offset_ff, hole_start_ff, hole_end_ff;
   logic [31:0] target_base_ff;

   // relocation table state
   logic             seen_high_ff, seen_high_in;
   logic             pend_active_ff, pend_active_in;
   logic             halted_ff, halted_in;
   logic [15:0]      addend_high_ff, addend_high_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // working registers for the current item
   req_item_type     item_ff, item_in;
   logic [31:0]      addr_ff, addr_in;
   logic [31:0]      sum_ff, sum_in;
   logic [15:0]      hi_ff, hi_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             res_we_ff, res_we_in;
   logic [31:0]      res_data_ff, res_data_in;
   status_type       res_status_ff, res_status_in;

   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;

   // shared adder
   logic [31:0] add_a, add_b, add_sum;

   // pending buffer ports
   logic             wr_en;
   logic [IDX_W-1:0] wr_idx;
   pend_entry_type   wr_entry;
   logic [CNT_W-1:0] rd_cnt;
   pend_entry_type   rd_entry;

   // item decode
   logic             req_take, out_free, is_local, in_hole;
   logic             eff_seen, eff_active, eff_halted;
   logic [15:0]      eff_addend;
   logic [CNT_W-1:0] eff_count, idx_next;
   logic [31:0]      word_sext16;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_item_ff;

   assign is_local    = item_ff.sym_section < LOCAL_LIMIT;
   assign in_hole     = (shorts_offset_ff != 32'd0) && (item_ff.sym_value >= hole_start_ff)
                        && (item_ff.sym_value < hole_end_ff);
   assign word_sext16 = {{16{item_ff.target_word[15]}}, item_ff.target_word[15:0]};

   // a new table clears the held state before the entry is looked at
   assign eff_seen   = item_ff.first_of_table ? 1'b0 : seen_high_ff;
   assign eff_active = item_ff.first_of_table ? 1'b0 : pend_active_ff;
   assign eff_halted = item_ff.first_of_table ? 1'b0 : halted_ff;
   assign eff_addend = item_ff.first_of_table ? 16'd0 : addend_high_ff;
   assign eff_count  = item_ff.first_of_table ? '0 : count_ff;
   assign idx_next   = idx_ff + CNT_W'(1);

   assign add_sum = add_a + add_b;

   mrp_pending_buf #(
      .DEPTH(PENDING_DEPTH)
   ) u_pending (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_idx  (wr_idx),
      .wr_entry(wr_entry),
      .rd_idx  (rd_cnt[IDX_W-1:0]),
      .rd_entry(rd_entry)
   );

   always_comb begin
      state_in       = state_ff;
      seen_high_in   = seen_high_ff;
      pend_active_in = pend_active_ff;
      halted_in      = halted_ff;
      addend_high_in = addend_high_ff;
      count_in       = count_ff;
      item_in        = item_ff;
      addr_in        = addr_ff;
      sum_in         = sum_ff;
      hi_in          = hi_ff;
      idx_in         = idx_ff;
      res_we_in      = res_we_ff;
      res_data_in    = res_data_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_chan.ready ? 1'b0 : rsp_valid_ff;
      rsp_item_in    = rsp_item_ff;
      add_a          = target_base_ff;
      add_b          = item_ff.target_offset;
      wr_en          = 1'b0;
      wr_idx         = eff_count[IDX_W-1:0];
      wr_entry       = '{address: add_sum, upper: item_ff.target_word[31:16]};
      rd_cnt         = idx_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               item_in  = req_chan.payload;
               state_in = S_ADDR;
            end
         end

         S_ADDR: begin
            // target address, and the decision on what the entry does
            addr_in        = add_sum;
            seen_high_in   = eff_seen;
            pend_active_in = eff_active;
            halted_in      = eff_halted;
            addend_high_in = eff_addend;
            count_in       = eff_count;
            res_we_in      = 1'b0;
            res_data_in    = 32'd0;
            res_status_in  = STATUS_OK;
            state_in       = S_FINAL;
            if (eff_halted) begin
               res_status_in = STATUS_HALTED;
            end else begin
               case (item_ff.reloc_kind) inside
                  REL_HI16: begin
                     if (eff_active || is_local) begin
                        if (eff_count >= DEPTH_CNT) begin
                           res_status_in = STATUS_OVERFLOW;
                           halted_in     = 1'b1;
                        end else begin
                           wr_en    = 1'b1;
                           count_in = eff_count + CNT_W'(1);
                           if (!eff_active) begin
                              pend_active_in = 1'b1;
                              seen_high_in   = 1'b1;
                              addend_high_in = item_ff.target_word[15:0];
                           end
                        end
                     end
                  end
                  REL_LO16: begin
                     if (is_local) begin
                        if (!eff_seen) begin
                           res_status_in = STATUS_LO_NO_HI;
                           halted_in     = 1'b1;
                        end else begin
                           state_in = S_CALC;
                        end
                     end
                  end
                  REL_WORD32, REL_JUMP26: begin
                     if (is_local) begin
                        state_in = S_CALC;
                     end
                  end
                  REL_GPREL16: begin
                     if (in_hole) begin
                        state_in = S_CALC;
                     end
                  end
                  default: begin
                     res_status_in = STATUS_BAD_TYPE;
                     halted_in     = 1'b1;
                  end
               endcase
            end
         end

         S_CALC: begin
            // patch add, operands chosen by type
            res_we_in = 1'b1;
            state_in  = S_FINAL;
            case (item_ff.reloc_kind)
               REL_WORD32: begin
                  add_a       = item_ff.target_word;
                  add_b       = segment_base_ff;
                  res_data_in = add_sum;
               end
               REL_JUMP26: begin
                  // sign-extended 26-bit field, in bytes
                  add_a       = {{4{item_ff.target_word[25]}}, item_ff.target_word[25:0], 2'b00};
                  add_b       = segment_base_ff;
                  res_data_in = {item_ff.target_word[31:26], add_sum[27:2]};
               end
               REL_GPREL16: begin
                  add_a       = word_sext16;
                  add_b       = shorts_offset_ff;
                  res_data_in = {item_ff.target_word[31:16], add_sum[15:0]};
               end
               default: begin
                  // lo16: high half of the addend plus the low half
                  add_a    = {addend_high_ff, 16'd0};
                  add_b    = word_sext16;
                  sum_in   = add_sum;
                  state_in = S_RELOC;
               end
            endcase
         end

         S_RELOC: begin
            add_a       = sum_ff;
            add_b       = segment_base_ff;
            sum_in      = add_sum;
            res_data_in = {item_ff.target_word[31:16], add_sum[15:0]};
            state_in    = pend_active_ff ? S_CARRY : S_FINAL;
         end

         S_CARRY: begin
            // rounded high half for every held hi16; start reading entry zero
            add_a    = sum_ff;
            add_b    = HI_ROUND;
            hi_in    = add_sum[31:16];
            idx_in   = '0;
            rd_cnt   = '0;
            state_in = S_FLUSH;
         end

         S_FLUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = '{write_enable: 1'b1, write_address: rd_entry.address,
                                write_data: {rd_entry.upper, hi_ff},
                                status: STATUS_OK, last: 1'b0};
               idx_in       = idx_next;
               rd_cnt       = idx_next;
               if (idx_next == count_ff) begin
                  pend_active_in = 1'b0;
                  count_in       = '0;
                  state_in       = S_FINAL;
               end
            end
         end

         S_FINAL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = '{write_enable: res_we_ff,
                                write_address: res_we_ff ? addr_ff : 32'd0,
                                write_data: res_data_ff, status: res_status_ff,
                                last: 1'b1};
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         seen_high_ff   <= 1'b0;
         pend_active_ff <= 1'b0;
         halted_ff      <= 1'b0;
         addend_high_ff <= 16'd0;
         count_ff       <= '0;
         idx_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         seen_high_ff   <= seen_high_in;
         pend_active_ff <= pend_active_in;
         halted_ff      <= halted_in;
         addend_high_ff <= addend_high_in;
         count_ff       <= count_in;
         idx_ff         <= idx_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      addr_ff       <= addr_in;
      sum_ff        <= sum_in;
      hi_ff         <= hi_in;
      res_we_ff     <= res_we_in;
      res_data_ff   <= res_data_in;
      res_status_ff <= res_status_in;
      rsp_item_ff   <= rsp_item_in;
   end

   // configuration writes; indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         segment_base_ff  <= 32'd0;
         shorts_offset_ff <= 32'd0;
         hole_start_ff    <= 32'd0;
         hole_end_ff      <= 32'd0;
         target_base_ff   <= 32'd0;
      end else if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_chan.payload.index)
            CSR_SEGMENT_BASE:  segment_base_ff  <= csr_chan.payload.data;
            CSR_SHORTS_OFFSET: shorts_offset_ff <= csr_chan.payload.data;
            CSR_HOLE_START:    hole_start_ff    <= csr_chan.payload.data;
            CSR_HOLE_END:      hole_end_ff      <= csr_chan.payload.data;
            CSR_TARGET_BASE:   target_base_ff   <= csr_chan.payload.data;
            default: ;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   // the buffer never holds more than its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("pending count beyond depth");

   // a flush only walks held entries
   a_flush_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FLUSH) |-> (pend_active_ff && (idx_ff < count_ff)))
      else $error("flush index outside held entries");

   // only flushed hi16 patches come before the last result, and they always store
   a_mid_result_writes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_item_ff.last) |-> (rsp_item_ff.write_enable
         && (rsp_item_ff.status == STATUS_OK)))
      else $error("non-final result without a store");

   // an active buffer always has at least one entry
   a_active_nonempty: assert property (@(posedge clock) disable iff (reset)
      pend_active_ff |-> (count_ff != '0))
      else $error("pending active with empty buffer");
`endif

endmodule

[bench/mips_elf_relocation_patcher_top_tb.sv]
// self-checking testbench for the mips elf32 rel relocation patcher
module mips_elf_relocation_patcher_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mrp_pkg::*;

   localparam int CLK_PERIOD    = 10;
   localparam int PEND_DEPTH    = 16;
   localparam int SETTLE_CYCLES = 32;        // settle time after the last expected item
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int HOLD_CYCLES   = 300;       // long receiver hold-off

   logic clock;
   logic reset;

   mrp_chan_if #(.payload_type(req_item_type)) req_chan();
   mrp_chan_if #(.payload_type(rsp_item_type)) rsp_chan();
   mrp_chan_if #(.payload_type(csr_item_type)) csr_chan();

   mips_elf_relocation_patcher_top #(
      .PENDING_DEPTH(PEND_DEPTH)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // mirror of the configuration registers
   logic [31:0] cfg_segment_base;
   logic [31:0] cfg_shorts_offset;
   logic [31:0] cfg_hole_start;
   logic [31:0] cfg_hole_end;
   logic [31:0] cfg_target_base;

   // mirror of the relocation state
   bit          seen_high;
   bit          pending_active;
   bit          halted;
   logic [15:0] addend_high;
   int          held_count;
   logic [31:0] held_address [PEND_DEPTH];
   logic [15:0] held_upper [PEND_DEPTH];

   // expected result items still to come out of the block, oldest first
   rsp_item_type expected_patches[$];

   int error_count;
   int cycle_count;

   // idling controls for sender and receiver
   bit req_idle_on;
   bit rsp_idle_on;
   int rsp_stall_left;
   int rsp_hold_left;

   // clock and reset
   initial clock = 1'b0;
   always #(CLK_PERIOD / 2) clock = ~clock;

   // every input known from time zero
   initial begin
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      csr_chan.valid   = 1'b0;
      csr_chan.payload = '0;
      rsp_chan.ready   = 1'b0;
   end

   // gap length: mostly none or short, now and then long
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 92) return $urandom_range(1, 3);
      else return $urandom_range(8, 40);
   endfunction

   function automatic logic [31:0] sign_extend16(logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------

   task automatic push_result(bit we, logic [31:0] addr, logic [31:0] data,
                              status_type st, bit last);
      rsp_item_type r;
      r.write_enable  = we;
      r.write_address = addr;
      r.write_data    = data;
      r.status        = st;
      r.last          = last;
      expected_patches.push_back(r);
   endtask

   // error path: the block halts until the next table
   task automatic stop_table(status_type st);
      halted = 1'b1;
      push_result(1'b0, '0, '0, st, 1'b1);
   endtask

   // works out the stores that one rel entry causes and updates the mirror
   task automatic apply_relocation(input req_item_type e);
      logic [31:0] addr;
      logic [31:0] word;
      logic [31:0] reloc;
      logic [31:0] rounded;
      logic [31:0] jump_field;
      bit          is_local;
      int          i;

      addr     = cfg_target_base + e.target_offset;
      word     = e.target_word;
      is_local = (e.sym_section < LOCAL_LIMIT);

      // a new table drops whatever the previous one left behind
      if (e.first_of_table) begin
         seen_high      = 1'b0;
         pending_active = 1'b0;
         halted         = 1'b0;
         addend_high    = '0;
         held_count     = 0;
      end

      if (halted) begin
         push_result(1'b0, '0, '0, STATUS_HALTED, 1'b1);
         return;
      end

      case (e.reloc_kind)
         REL_HI16: begin
            if (!pending_active && !is_local) begin
               // non-local hi16 with nothing held is ignored
               push_result(1'b0, '0, '0, STATUS_OK, 1'b1);
            end else if (held_count >= PEND_DEPTH) begin
               stop_table(STATUS_OVERFLOW);
            end else begin
               // only the first held hi16 supplies the addend
               if (!pending_active) begin
                  pending_active = 1'b1;
                  seen_high      = 1'b1;
                  addend_high    = word[15:0];
                  held_count     = 0;
               end
               held_address[held_count] = addr;
               held_upper[held_count]   = word[31:16];
               held_count++;
               push_result(1'b0, '0, '0, STATUS_OK, 1'b1);
            end
         end
         REL_LO16: begin
            if (!is_local) begin
               push_result(1'b0, '0, '0, STATUS_OK, 1'b1);
            end else if (!seen_high) begin
               stop_table(STATUS_LO_NO_HI);
            end else begin
               reloc = {addend_high, 16'h0000} + sign_extend16(word[15:0])
                       + cfg_segment_base;
               if (pending_active) begin
                  // back-patch every held hi16 with the rounded upper half
                  rounded = reloc + HI_ROUND;
                  for (i = 0; i < held_count; i++)
                     push_result(1'b1, held_address[i], {held_upper[i], rounded[31:16]},
                                 STATUS_OK, 1'b0);
                  pending_active = 1'b0;
                  held_count     = 0;
               end
               push_result(1'b1, addr, {word[31:16], reloc[15:0]}, STATUS_OK, 1'b1);
            end
         end
         REL_JUMP26: begin
            if (!is_local) begin
               push_result(1'b0, '0, '0, STATUS_OK, 1'b1);
            end else begin
               jump_field = {{6{word[25]}}, word[25:0]};
               reloc      = ((jump_field << 2) + cfg_segment_base) >> 2;
               push_result(1'b1, addr, {word[31:26], reloc[25:0]}, STATUS_OK, 1'b1);
            end
         end
         REL_GPREL16: begin
            if (cfg_shorts_offset == '0 || e.sym_value < cfg_hole_start ||
                e.sym_value >= cfg_hole_end) begin
               push_result(1'b0, '0, '0, STATUS_OK, 1'b1);
            end else begin
               reloc = sign_extend16(word[15:0]) + cfg_shorts_offset;
               push_result(1'b1, addr, {word[31:16], reloc[15:0]}, STATUS_OK, 1'b1);
            end
         end
         REL_WORD32: begin
            if (!is_local)
               push_result(1'b0, '0, '0, STATUS_OK, 1'b1);
            else
               push_result(1'b1, addr, word + cfg_segment_base, STATUS_OK, 1'b1);
         end
         default: begin
            stop_table(STATUS_BAD_TYPE);
         end
      endcase
   endtask

   // ------------------------------------------------------------------
   // driving
   // ------------------------------------------------------------------

   // offer one rel entry, predict at acceptance, then maybe idle
   task automatic send_entry(input req_item_type e);
      int gap;
      req_chan.valid   <= 1'b1;
      req_chan.payload <= e;
      do @(posedge clock); while (!req_chan.ready);
      apply_relocation(e);
      gap = req_idle_on ? idle_gap() : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop offering, wait for every expected item, then let the block settle
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (expected_patches.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // registers only change with the block idle
   task automatic load_config(input logic [31:0] seg, input logic [31:0] shorts,
                              input logic [31:0] hs, input logic [31:0] he,
                              input logic [31:0] tbase);
      csr_index_type idx [5];
      logic [31:0]   vals [5];
      int            i;
      idx[0] = CSR_SEGMENT_BASE;   vals[0] = seg;
      idx[1] = CSR_SHORTS_OFFSET;  vals[1] = shorts;
      idx[2] = CSR_HOLE_START;     vals[2] = hs;
      idx[3] = CSR_HOLE_END;       vals[3] = he;
      idx[4] = CSR_TARGET_BASE;    vals[4] = tbase;
      drain_results();
      for (i = 0; i < 5; i++) begin
         csr_chan.valid         <= 1'b1;
         csr_chan.payload.index <= idx[i];
         csr_chan.payload.data  <= vals[i];
         do @(posedge clock); while (!csr_chan.ready);
         case (idx[i])
            CSR_SEGMENT_BASE:  cfg_segment_base  = vals[i];
            CSR_SHORTS_OFFSET: cfg_shorts_offset = vals[i];
            CSR_HOLE_START:    cfg_hole_start    = vals[i];
            CSR_HOLE_END:      cfg_hole_end      = vals[i];
            CSR_TARGET_BASE:   cfg_target_base   = vals[i];
            default: ;
         endcase
      end
      csr_chan.valid <= 1'b0;
   endtask

   function automatic req_item_type make_entry(bit first, logic [7:0] kind,
                                               logic [15:0] sect, logic [31:0] sval,
                                               logic [31:0] offs, logic [31:0] word);
      req_item_type e;
      e.first_of_table = first;
      e.reloc_kind     = kind;
      e.sym_section    = sect;
      e.sym_value      = sval;
      e.target_offset  = offs;
      e.target_word    = word;
      return e;
   endfunction

   // random content; symbol values lean into the short-data hole
   function automatic req_item_type random_entry(logic [7:0] kind, bit is_local);
      logic [15:0] sect;
      logic [31:0] sval;
      sect = is_local ? 16'($urandom_range(0, 16'hfeff))
                      : 16'($urandom_range(16'hff00, 16'hffff));
      if (cfg_hole_end > cfg_hole_start && $urandom_range(0, 1))
         sval = cfg_hole_start + $urandom_range(0, cfg_hole_end - cfg_hole_start - 1);
      else
         sval = $urandom;
      // start a new table most of the time once the block has halted
      return make_entry(halted && $urandom_range(0, 4) != 0, kind, sect, sval,
                        $urandom, $urandom);
   endfunction

   // ------------------------------------------------------------------
   // receiver: random stalls, plus the long hold-off the pressure test asks
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
         rsp_hold_left  = rsp_hold_left - 1;
      end else if (rsp_stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall_left = rsp_stall_left - 1;
      end else if (rsp_idle_on && $urandom_range(0, 3) == 0) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall_left = idle_gap();
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // checker: every accepted item against the oldest expectation
   // ------------------------------------------------------------------
   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%08h, actual 0x%08h", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : check_results
      rsp_item_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_patches.size() == 0) begin
            $error("result item with nothing expected: we=%0b addr=0x%08h data=0x%08h",
                   rsp_chan.payload.write_enable, rsp_chan.payload.write_address,
                   rsp_chan.payload.write_data);
            error_count++;
         end else begin
            want = expected_patches.pop_front();
            check_field("write_enable", 32'(want.write_enable),
                        32'(rsp_chan.payload.write_enable));
            check_field("write_address", want.write_address,
                        rsp_chan.payload.write_address);
            check_field("write_data", want.write_data, rsp_chan.payload.write_data);
            check_field("status", 32'(want.status), 32'(rsp_chan.payload.status));
            check_field("last", 32'(want.last), 32'(rsp_chan.payload.last));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // registers still at reset: no load offset, gprel16 disabled
   task automatic test_reset_config();
      send_entry(make_entry(1'b0, REL_WORD32, 16'h0000, 32'h0, 32'h0000_0100, 32'h1234_5678));
      send_entry(make_entry(1'b0, REL_GPREL16, 16'h0001, 32'h0, 32'h0000_0104, 32'h2784_0010));
      send_entry(make_entry(1'b0, REL_JUMP26, 16'h0002, 32'h0, 32'h0000_0108, 32'h0c00_0040));
   endtask

   // all-ones registers but a zero hole start, and field extremes; address and data wrap
   task automatic test_field_extremes();
      load_config('1, '1, '0, '1, '1);
      send_entry(make_entry(1'b0, REL_WORD32, 16'hfeff, '1, '1, '1));
      // lowest and highest non-local section
      send_entry(make_entry(1'b0, REL_WORD32, 16'hff00, '0, '0, '1));
      send_entry(make_entry(1'b0, REL_WORD32, 16'hffff, '0, '0, '1));
      // negative and zero jump fields
      send_entry(make_entry(1'b0, REL_JUMP26, 16'h0000, '0, '0, '1));
      send_entry(make_entry(1'b0, REL_JUMP26, 16'h0000, '1, '1, '0));
      // hole end is exclusive
      send_entry(make_entry(1'b0, REL_GPREL16, 16'hffff, '1, '0, '1));
      send_entry(make_entry(1'b0, REL_GPREL16, 16'hffff, '0, '0, '1));
   endtask

   // gprel16 inside, at the edges of, and outside the hole
   task automatic test_short_data();
      load_config(32'h0, 32'h0000_8000, 32'h0000_1000, 32'h0000_2000, 32'h0040_0000);
      send_entry(make_entry(1'b0, REL_GPREL16, 16'h0005, 32'h0000_1000, 32'h10, 32'h8fa2_8000));
      send_entry(make_entry(1'b0, REL_GPREL16, 16'h0005, 32'h0000_1fff, 32'h14, 32'h8fa2_7fff));
      send_entry(make_entry(1'b0, REL_GPREL16, 16'h0005, 32'h0000_2000, 32'h18, 32'h8fa2_0004));
      send_entry(make_entry(1'b0, REL_GPREL16, 16'h0005, 32'h0000_0fff, 32'h1c, 32'h8fa2_0008));
   endtask

   // hi16 held, joined, flushed by lo16 with carry; lo16 reused afterwards
   task automatic test_hi_lo_pairing();
      load_config(32'h1, 32'h0, 32'h0, 32'h0, 32'h8000_0000);
      send_entry(make_entry(1'b1, REL_HI16, 16'h0003, '0, 32'h10, 32'h3c01_ffff));
      // non-local hi16 joins once something is held
      send_entry(make_entry(1'b0, REL_HI16, 16'hff01, '0, 32'h20, 32'h3c02_1234));
      send_entry(make_entry(1'b0, REL_HI16, 16'h0004, '0, 32'h30, 32'h3c03_0000));
      // rounding carry wraps the upper half to zero
      send_entry(make_entry(1'b0, REL_LO16, 16'h0003, '0, 32'h40, 32'h2421_7fff));
      // repeated lo16 patches only itself with the old addend
      send_entry(make_entry(1'b0, REL_LO16, 16'h0003, '0, 32'h44, 32'h8c42_8000));
      send_entry(make_entry(1'b0, REL_LO16, 16'hffff, '0, 32'h48, 32'h8c42_0000));
      // non-local hi16 with nothing held is ignored
      send_entry(make_entry(1'b0, REL_HI16, 16'hff00, '0, 32'h50, 32'h3c05_0001));
      send_entry(make_entry(1'b0, REL_HI16, 16'h0001, '0, 32'h60, 32'h3c04_0001));
      send_entry(make_entry(1'b0, REL_LO16, 16'h0001, '0, 32'h64, 32'h2484_0000));
   endtask

   // each error halts the block until a new table starts
   task automatic test_error_halt();
      send_entry(make_entry(1'b1, REL_LO16, 16'h0000, '0, 32'h70, 32'h2421_0010));
      send_entry(make_entry(1'b0, REL_WORD32, 16'h0000, '0, 32'h74, 32'h0000_0001));
      send_entry(make_entry(1'b1, 8'h00, 16'h0000, '0, 32'h78, 32'h0));
      send_entry(make_entry(1'b0, 8'hff, 16'h0000, '0, 32'h7c, 32'h0));
      send_entry(make_entry(1'b1, 8'hff, 16'h0000, '0, 32'h80, 32'h0));
      send_entry(make_entry(1'b1, REL_WORD32, 16'h0000, '0, 32'h84, 32'h0000_0002));
   endtask

   // a full buffer flushed by one lo16, then one hi16 too many
   task automatic test_pending_limits();
      req_item_type e;
      int           i;
      for (i = 0; i < PEND_DEPTH; i++) begin
         e = random_entry(REL_HI16, 1'b1);
         e.first_of_table = (i == 0);
         send_entry(e);
      end
      send_entry(random_entry(REL_LO16, 1'b1));
      for (i = 0; i <= PEND_DEPTH; i++) begin
         e = random_entry(REL_HI16, 1'b1);
         e.first_of_table = (i == 0);
         send_entry(e);
      end
      send_entry(make_entry(1'b0, REL_WORD32, 16'h0000, '0, 32'h90, 32'h0));
   endtask

   // receiver holds off while the sender keeps offering, so the block stalls
   task automatic test_backpressure();
      req_item_type e;
      int           i;
      req_idle_on   = 1'b0;
      rsp_hold_left = HOLD_CYCLES;
      for (i = 0; i < 4; i++) begin
         e = random_entry(REL_WORD32, 1'b1);
         e.first_of_table = (i == 0);
         send_entry(e);
      end
      for (i = 0; i < 3; i++) send_entry(random_entry(REL_HI16, 1'b1));
      send_entry(random_entry(REL_LO16, 1'b1));
      send_entry(random_entry(REL_JUMP26, 1'b1));
      send_entry(random_entry(REL_GPREL16, 1'b1));
      req_idle_on = 1'b1;
   endtask

   // mostly hi16 runs closed by lo16, some single patches, some noise
   task automatic random_phase(int n_items);
      req_item_type e;
      int           sent;
      int           r;
      int           n_high;
      int           i;
      sent = 0;
      while (sent < n_items) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            r = $urandom_range(0, 99);
            if (r < 6) n_high = PEND_DEPTH;
            else if (r < 9) n_high = PEND_DEPTH + 1;
            else n_high = $urandom_range(1, 3);
            for (i = 0; i < n_high; i++) begin
               // later hi16 entries may be non-local; they still join
               e = random_entry(REL_HI16, i == 0 || $urandom_range(0, 3) != 0);
               if (i == 0 && $urandom_range(0, 2) == 0) e.first_of_table = 1'b1;
               send_entry(e);
            end
            send_entry(random_entry(REL_LO16, $urandom_range(0, 9) != 0));
            sent += n_high + 1;
            if ($urandom_range(0, 3) == 0) begin
               send_entry(random_entry(REL_LO16, 1'b1));
               sent++;
            end
         end else if (r < 88) begin
            case ($urandom_range(0, 4))
               0:       e = random_entry(REL_WORD32, $urandom_range(0, 7) != 0);
               1:       e = random_entry(REL_JUMP26, $urandom_range(0, 7) != 0);
               2, 3:    e = random_entry(REL_GPREL16, 1'($urandom_range(0, 1)));
               default: e = random_entry(REL_LO16, $urandom_range(0, 7) != 0);
            endcase
            send_entry(e);
            sent++;
         end else begin
            // any type, any section, table start at random
            e = random_entry(8'($urandom_range(0, 255)), 1'b1);
            e.sym_section    = 16'($urandom);
            e.first_of_table = 1'($urandom_range(0, 1));
            send_entry(e);
            sent++;
         end
      end
   endtask

   task automatic test_random_phases();
      logic [31:0] hs;
      // stretch with no idling on either side
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      load_config($urandom, $urandom, $urandom, $urandom, $urandom);
      random_phase(35);
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      // gprel16 disabled, hole empty
      load_config('0, '0, '1, '0, '0);
      random_phase(35);
      // narrow hole, small offsets
      hs = $urandom;
      load_config($urandom_range(0, 32'h0001_ffff), $urandom_range(1, 32'hffff), hs,
                  hs + $urandom_range(1, 32'h0100_0000), $urandom_range(0, 32'hffff));
      random_phase(35);
      // extremes again
      load_config('1, '1, '0, '1, '1);
      random_phase(35);
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      cfg_segment_base  = '0;
      cfg_shorts_offset = '0;
      cfg_hole_start    = '0;
      cfg_hole_end      = '0;
      cfg_target_base   = '0;
      seen_high         = 1'b0;
      pending_active    = 1'b0;
      halted            = 1'b0;
      addend_high       = '0;
      held_count        = 0;
      error_count       = 0;
      cycle_count       = 0;
      rsp_stall_left    = 0;
      rsp_hold_left     = 0;
      req_idle_on       = 1'b1;
      rsp_idle_on       = 1'b1;

      // synchronous reset
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_config();
      test_field_extremes();
      test_short_data();
      test_hi_lo_pairing();
      test_error_halt();
      test_pending_limits();
      test_backpressure();
      test_random_phases();

      drain_results();
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[sim.f]
rtl/mrp_pkg.sv
rtl/mrp_chan_if.sv
rtl/mrp_pending_buf.sv
rtl/mips_elf_relocation_patcher_top.sv
bench/mips_elf_relocation_patcher_top_tb.sv
